>>> rtl/hcra_pkg.sv
// Shared types and constants for the HEVC configuration record to Annex-B converter.
// Used by the parser, the emitter, the top level and the port checker.
`timescale 1ns / 1ps
package hcra_pkg;

  localparam int unsigned HEADER_BYTES = 22;
  localparam int unsigned SC_LEN       = 4;

  localparam logic [7:0] TYPE_MASK     = 8'h3f;
  localparam logic [5:0] TYPE_VPS      = 6'd32;
  localparam logic [5:0] TYPE_SPS      = 6'd33;
  localparam logic [5:0] TYPE_PPS      = 6'd34;
  localparam logic [7:0] SC_ZERO_BYTE  = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE  = 8'h01;

  // Unit kind codes on the result channel
  localparam logic [1:0] KIND_VPS      = 2'd0;
  localparam logic [1:0] KIND_SPS      = 2'd1;
  localparam logic [1:0] KIND_PPS      = 2'd2;

  typedef struct packed {
    logic [7:0] rec_byte;
    logic       rec_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] unit_kind;
    logic       unit_first;
    logic       unit_end;
    logic       run_last;
  } out_t;

  // One emitted payload byte as handed from the parser to the emitter
  typedef struct packed {
    logic [7:0] pay_byte;
    logic [1:0] kind;
    logic       fresh;
    logic       last_byte;
  } tok_t;

endpackage

>>> rtl/hcra_parse.sv
// Record parser: walks header, arrays, unit counts and lengths one byte at a time.
// Registers one token per emitted payload byte. Depends on hcra_pkg.
`timescale 1ns / 1ps
module hcra_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hcra_pkg::in_t   in_data,
  output logic            tok_valid,
  output hcra_pkg::tok_t  tok,
  input  logic            tok_ready
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_UCNT_HI,
    PH_UCNT_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  phase_e          phase_r, phase_nxt, phase_eff;
  logic [4:0]      hdr_cnt_r, hdr_cnt_nxt, hdr_cnt_eff;
  logic [7:0]      arrays_r, arrays_nxt;
  logic [15:0]     units_r, units_nxt;
  logic [15:0]     bytes_r, bytes_nxt;
  logic [5:0]      type_r, type_nxt;
  logic [7:0]      hold_r, hold_nxt;
  logic            fresh_r, fresh_nxt;
  logic            tok_v_r, tok_v_nxt;
  hcra_pkg::tok_t  tok_r, tok_nxt;
  logic            accept;
  logic            emit_type;
  logic            new_tok;
  logic [15:0]     count16;

  // Take a byte when the token slot is free or drains this cycle
  assign in_stall = tok_v_r && !tok_ready;
  assign accept   = in_valid && !in_stall;

  assign emit_type = (type_r == hcra_pkg::TYPE_VPS) || (type_r == hcra_pkg::TYPE_SPS) ||
                     (type_r == hcra_pkg::TYPE_PPS);
  assign count16   = {hold_r, in_data.rec_byte};

  // Parse step: a record start restarts the header walk with this byte
  always_comb begin
    phase_eff   = in_data.rec_start ? PH_HEADER : phase_r;
    hdr_cnt_eff = in_data.rec_start ? 5'd0 : hdr_cnt_r;
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    arrays_nxt  = arrays_r;
    units_nxt   = units_r;
    bytes_nxt   = bytes_r;
    type_nxt    = type_r;
    hold_nxt    = hold_r;
    fresh_nxt   = fresh_r;
    new_tok     = 1'b0;
    tok_nxt     = tok_r;
    if (accept) begin
      phase_nxt   = phase_eff;
      hdr_cnt_nxt = hdr_cnt_eff;
      unique case (phase_eff)
        PH_HEADER: begin
          if (hdr_cnt_eff < 5'(hcra_pkg::HEADER_BYTES)) begin
            hdr_cnt_nxt = hdr_cnt_eff + 5'd1;
          end else begin
            hdr_cnt_nxt = 5'(hcra_pkg::HEADER_BYTES + 1);
            arrays_nxt  = in_data.rec_byte;
            phase_nxt   = (in_data.rec_byte != 8'd0) ? PH_TYPE : PH_DONE;
          end
        end
        PH_TYPE: begin
          type_nxt  = 6'(in_data.rec_byte & hcra_pkg::TYPE_MASK);
          phase_nxt = PH_UCNT_HI;
        end
        PH_UCNT_HI: begin
          hold_nxt  = in_data.rec_byte;
          phase_nxt = PH_UCNT_LO;
        end
        PH_UCNT_LO: begin
          units_nxt = count16;
          if (count16 == 16'd0) begin
            arrays_nxt = arrays_r - 8'd1;
            phase_nxt  = (arrays_r != 8'd1) ? PH_TYPE : PH_DONE;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          hold_nxt  = in_data.rec_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_nxt = count16;
          if (count16 == 16'd0) begin
            // Empty unit: skip it, close the array when it was the last unit
            units_nxt = units_r - 16'd1;
            if (units_r == 16'd1) begin
              arrays_nxt = arrays_r - 8'd1;
              phase_nxt  = (arrays_r != 8'd1) ? PH_TYPE : PH_DONE;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end else begin
            fresh_nxt = 1'b1;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          new_tok           = emit_type;
          tok_nxt.pay_byte  = in_data.rec_byte;
          tok_nxt.kind      = type_r[1:0];
          tok_nxt.fresh     = fresh_r;
          tok_nxt.last_byte = (bytes_r <= 16'd1);
          fresh_nxt         = 1'b0;
          bytes_nxt         = bytes_r - 16'd1;
          if (bytes_r == 16'd1) begin
            units_nxt = units_r - 16'd1;
            if (units_r == 16'd1) begin
              arrays_nxt = arrays_r - 8'd1;
              phase_nxt  = (arrays_r != 8'd1) ? PH_TYPE : PH_DONE;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
    // Hold the token until the emitter takes its last output
    priority if (new_tok) begin
      tok_v_nxt = 1'b1;
    end else if (tok_ready) begin
      tok_v_nxt = 1'b0;
    end else begin
      tok_v_nxt = tok_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 5'd0;
      arrays_r  <= 8'd0;
      units_r   <= 16'd0;
      bytes_r   <= 16'd0;
      type_r    <= 6'd0;
      hold_r    <= 8'd0;
      fresh_r   <= 1'b0;
      tok_v_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      arrays_r  <= arrays_nxt;
      units_r   <= units_nxt;
      bytes_r   <= bytes_nxt;
      type_r    <= type_nxt;
      hold_r    <= hold_nxt;
      fresh_r   <= fresh_nxt;
      tok_v_r   <= tok_v_nxt;
    end
    tok_r <= tok_nxt;
  end

  assign tok_valid = tok_v_r;
  assign tok       = tok_r;

endmodule

>>> rtl/hcra_emit.sv
// Emitter: expands a unit's first payload byte into start code plus byte,
// and holds the result register. Depends on hcra_pkg.
`timescale 1ns / 1ps
module hcra_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  hcra_pkg::tok_t  tok,
  output logic            tok_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output hcra_pkg::out_t  out_data
);

  logic            out_v_r, out_v_nxt;
  hcra_pkg::out_t  out_r, out_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            load;
  logic            on_payload;

  // Result register is free when empty or draining
  assign load       = tok_valid && (!out_v_r || !out_stall);
  assign on_payload = !tok.fresh || (step_r == 3'(hcra_pkg::SC_LEN));
  assign tok_ready  = load && on_payload;

  // Pick the next output transaction of the held token
  always_comb begin
    out_nxt   = out_r;
    step_nxt  = step_r;
    out_v_nxt = load || (out_v_r && out_stall);
    if (load) begin
      out_nxt.unit_kind = tok.kind;
      if (on_payload) begin
        out_nxt.out_byte   = tok.pay_byte;
        out_nxt.unit_first = 1'b0;
        out_nxt.unit_end   = tok.last_byte;
        out_nxt.run_last   = 1'b1;
        step_nxt           = 3'd0;
      end else begin
        out_nxt.out_byte   = (step_r == 3'(hcra_pkg::SC_LEN - 1)) ?
                             hcra_pkg::SC_LAST_BYTE : hcra_pkg::SC_ZERO_BYTE;
        out_nxt.unit_first = (step_r == 3'd0);
        out_nxt.unit_end   = 1'b0;
        out_nxt.run_last   = 1'b0;
        step_nxt           = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      step_r  <= 3'd0;
    end else begin
      out_v_r <= out_v_nxt;
      step_r  <= step_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/hevc_config_record_to_annexb_core.sv
// HEVC configuration record to Annex-B parameter sets, one record byte per transaction.
// A payload byte's first result goes through the token register, then the result register.
// Throughput: one byte per cycle unless the result side stalls; a unit's first payload byte
// yields five results (start code plus byte), holding the input off during the start code.
// Reset (rst_n low, synchronous) clears the parser to the header phase and empties
// the token and result registers. Depends on hcra_pkg, hcra_parse, hcra_emit.
`timescale 1ns / 1ps
module hevc_config_record_to_annexb_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hcra_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hcra_pkg::out_t  out_data
);

  logic            tok_valid;
  logic            tok_ready;
  hcra_pkg::tok_t  tok;

  // Parse record bytes into payload tokens
  hcra_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready)
  );

  // Expand tokens into Annex-B output transactions
  hcra_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/hcra_checker.sv
// Port checker for the converter top level, attached by bind.
// Depends on hcra_pkg and hevc_config_record_to_annexb_core.
`timescale 1ns / 1ps
module hcra_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            out_valid,
  input  logic            out_stall,
  input  hcra_pkg::out_t  out_data
);

  // Result channel empties during reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Start code bytes are zero or one and never close a run or a unit
  a_start_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |->
      !out_data.unit_end &&
      (out_data.out_byte == hcra_pkg::SC_ZERO_BYTE ||
       out_data.out_byte == hcra_pkg::SC_LAST_BYTE))
    else $error("bad start code transaction");

  // First start code byte is a zero and not the run's end
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unit_first |->
      !out_data.run_last && out_data.out_byte == hcra_pkg::SC_ZERO_BYTE)
    else $error("bad unit first transaction");

  // Unit kind stays within VPS, SPS, PPS
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.unit_kind == hcra_pkg::KIND_VPS ||
                  out_data.unit_kind == hcra_pkg::KIND_SPS ||
                  out_data.unit_kind == hcra_pkg::KIND_PPS)
    else $error("unit kind out of range");

endmodule

bind hevc_config_record_to_annexb_core hcra_checker u_hcra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/hevc_config_record_to_annexb_core_tb.sv
// Self-checking testbench for hevc_config_record_to_annexb_core: feeds configuration records
// byte by byte and compares every Annex-B result byte with a built-in parser model.
// Depends on hcra_pkg and the core RTL only.
`timescale 1ns / 1ps
module hevc_config_record_to_annexb_core_tb;

  typedef enum logic [2:0] {
    P_HEADER, P_TYPE, P_UCNT_HI, P_UCNT_LO, P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_DONE
  } rec_phase_e;

  localparam logic [5:0] TYPE_SEI = 6'd39;

  // Parser model plus the queue of Annex-B bytes it expects
  class annexb_scoreboard;
    hcra_pkg::out_t annexb_expected[$];
    int          err_count;
    int          bytes_checked;
    rec_phase_e  ph;
    logic [4:0]  hdr_cnt;
    logic [7:0]  arrays_left;
    logic [15:0] units_left;
    logic [15:0] bytes_left;
    logic [5:0]  cur_type;
    logic [7:0]  hi_hold;
    logic        fresh;

    function new();
      err_count     = 0;
      bytes_checked = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      ph          = P_HEADER;
      hdr_cnt     = '0;
      arrays_left = '0;
      units_left  = '0;
      bytes_left  = '0;
      cur_type    = '0;
      hi_hold     = '0;
      fresh       = 1'b0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      err_count++;
    endtask

    function void close_array();
      arrays_left = arrays_left - 8'd1;
      ph = (arrays_left != 0) ? P_TYPE : P_DONE;
    endfunction

    function void close_unit();
      units_left = units_left - 16'd1;
      if (units_left == 0) close_array();
      else ph = P_LEN_HI;
    endfunction

    function void push_byte(logic [7:0] b, logic [1:0] kind, logic first, logic last_b,
                            logic run_end);
      hcra_pkg::out_t r;
      r.out_byte   = b;
      r.unit_kind  = kind;
      r.unit_first = first;
      r.unit_end   = last_b;
      r.run_last   = run_end;
      annexb_expected.push_back(r);
    endfunction

    // Advance the parser by one accepted record byte
    function void note_record_byte(hcra_pkg::in_t t);
      logic [7:0] b;
      logic [1:0] kind;
      logic       emit;
      b = t.rec_byte;
      if (t.rec_start) clear_parser();
      case (ph)
        P_HEADER: begin
          if (hdr_cnt < hcra_pkg::HEADER_BYTES) begin
            hdr_cnt = hdr_cnt + 5'd1;
          end else begin
            hdr_cnt     = 5'(hcra_pkg::HEADER_BYTES + 1);
            arrays_left = b;
            ph = (b != 0) ? P_TYPE : P_DONE;
          end
        end
        P_TYPE: begin
          cur_type = b[5:0];
          ph = P_UCNT_HI;
        end
        P_UCNT_HI: begin
          hi_hold = b;
          ph = P_UCNT_LO;
        end
        P_UCNT_LO: begin
          units_left = {hi_hold, b};
          if (units_left == 0) close_array();
          else ph = P_LEN_HI;
        end
        P_LEN_HI: begin
          hi_hold = b;
          ph = P_LEN_LO;
        end
        P_LEN_LO: begin
          bytes_left = {hi_hold, b};
          if (bytes_left == 0) begin
            close_unit();
          end else begin
            fresh = 1'b1;
            ph = P_PAYLOAD;
          end
        end
        P_PAYLOAD: begin
          emit = (cur_type == hcra_pkg::TYPE_VPS) || (cur_type == hcra_pkg::TYPE_SPS) ||
                 (cur_type == hcra_pkg::TYPE_PPS);
          kind = (cur_type == hcra_pkg::TYPE_VPS) ? hcra_pkg::KIND_VPS :
                 (cur_type == hcra_pkg::TYPE_SPS) ? hcra_pkg::KIND_SPS : hcra_pkg::KIND_PPS;
          if (emit) begin
            // Prefix the first payload byte with the start code
            if (fresh) begin
              push_byte(hcra_pkg::SC_ZERO_BYTE, kind, 1'b1, 1'b0, 1'b0);
              push_byte(hcra_pkg::SC_ZERO_BYTE, kind, 1'b0, 1'b0, 1'b0);
              push_byte(hcra_pkg::SC_ZERO_BYTE, kind, 1'b0, 1'b0, 1'b0);
              push_byte(hcra_pkg::SC_LAST_BYTE, kind, 1'b0, 1'b0, 1'b0);
            end
            push_byte(b, kind, 1'b0, bytes_left <= 1, 1'b1);
          end
          fresh = 1'b0;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 0) close_unit();
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    task check_annexb_byte(hcra_pkg::out_t got);
      hcra_pkg::out_t exp_r;
      if (annexb_expected.size() == 0) begin
        report($sformatf("unexpected result byte %02h", got.out_byte));
      end else begin
        exp_r = annexb_expected.pop_front();
        bytes_checked++;
        if (got.out_byte !== exp_r.out_byte)
          report($sformatf("out_byte %02h, want %02h", got.out_byte, exp_r.out_byte));
        if (got.unit_kind !== exp_r.unit_kind)
          report($sformatf("unit_kind %0d, want %0d", got.unit_kind, exp_r.unit_kind));
        if (got.unit_first !== exp_r.unit_first)
          report($sformatf("unit_first %0b, want %0b", got.unit_first, exp_r.unit_first));
        if (got.unit_end !== exp_r.unit_end)
          report($sformatf("unit_end %0b, want %0b", got.unit_end, exp_r.unit_end));
        if (got.run_last !== exp_r.run_last)
          report($sformatf("run_last %0b, want %0b", got.run_last, exp_r.run_last));
      end
    endtask

    function int pending();
      return annexb_expected.size();
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  hcra_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  hcra_pkg::out_t out_data;

  annexb_scoreboard sb = new();
  hcra_pkg::in_t record_q[$];
  int  records_built = 0;

  always #5 clk = ~clk;

  hevc_config_record_to_annexb_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  task add_byte(logic [7:0] b, logic first);
    hcra_pkg::in_t t;
    t.rec_byte  = b;
    t.rec_start = first;
    record_q.push_back(t);
  endtask

  task add_header(logic first, logic [7:0] fill);
    add_byte(fill, first);
    for (int i = 1; i < hcra_pkg::HEADER_BYTES; i++) add_byte((i % 2) ? ~fill : fill, 1'b0);
  endtask

  task add_unit(logic [15:0] len, logic [7:0] seed);
    add_byte(len[15:8], 1'b0);
    add_byte(len[7:0], 1'b0);
    for (int i = 0; i < len; i++) add_byte(seed + 8'(i * 37), 1'b0);
  endtask

  // Build one random record; a cut record is truncated and may carry huge counts
  task add_random_record();
    int          base, cut_at, n_arr, sel;
    logic        cut;
    logic [7:0]  arr_byte, typ;
    logic [15:0] ucount, len;
    base   = record_q.size();
    cut    = ($urandom_range(0, 4) == 0);
    cut_at = cut ? int'($urandom_range(24, 60)) : 32'h7fff_ffff;
    add_byte(8'($urandom_range(0, 255)), 1'b1);
    for (int i = 1; i < hcra_pkg::HEADER_BYTES; i++)
      add_byte(8'($urandom_range(0, 255)), 1'b0);
    if ($urandom_range(0, 9) == 0) arr_byte = 8'd0;
    else if (cut) arr_byte = 8'($urandom_range(1, 255));
    else arr_byte = 8'($urandom_range(1, 4));
    add_byte(arr_byte, 1'b0);
    n_arr = (arr_byte > 4) ? 4 : int'(arr_byte);
    for (int a = 0; a < n_arr && record_q.size() - base < cut_at; a++) begin
      sel = int'($urandom_range(0, 9));
      typ[7:6] = 2'($urandom_range(0, 3));
      if (sel <= 2) typ[5:0] = hcra_pkg::TYPE_VPS;
      else if (sel <= 5) typ[5:0] = hcra_pkg::TYPE_SPS;
      else if (sel <= 7) typ[5:0] = hcra_pkg::TYPE_PPS;
      else if (sel == 8) typ[5:0] = TYPE_SEI;
      else typ[5:0] = 6'($urandom_range(0, 63));
      add_byte(typ, 1'b0);
      if ($urandom_range(0, 9) == 0) ucount = 16'd0;
      else if (cut && $urandom_range(0, 2) == 0) ucount = 16'($urandom_range(256, 65535));
      else ucount = 16'($urandom_range(1, 3));
      add_byte(ucount[15:8], 1'b0);
      add_byte(ucount[7:0], 1'b0);
      for (int u = 0; u < ucount && record_q.size() - base < cut_at; u++) begin
        if ($urandom_range(0, 9) == 0) len = 16'd0;
        else if (cut && $urandom_range(0, 2) == 0) len = 16'($urandom_range(256, 65535));
        else len = 16'($urandom_range(1, 8));
        add_byte(len[15:8], 1'b0);
        add_byte(len[7:0], 1'b0);
        for (int k = 0; k < len && record_q.size() - base < cut_at; k++)
          add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if (cut) begin
      while (record_q.size() - base > cut_at) void'(record_q.pop_back());
    end else begin
      // Trailing noise past the end of the record
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    records_built++;
  endtask

  // Offer one transaction after a random gap (none in burst mode) and hold it until accepted
  task send_record_byte(hcra_pkg::in_t t, bit burst);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sb.note_record_byte(t);
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int  n_seen, hold;
    bit  burst;
    n_seen = 0;
    burst  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (n_seen % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      hold = (n_seen == 40) ? 300 : (burst ? 0 : int'($urandom_range(0, 13)));
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_annexb_byte(out_data);
      n_seen++;
    end
  end

  // Main sequence: directed records, random records, drain, verdict
  initial begin
    int  drain;
    bit  burst;
    // Record straight after reset without rec_start; VPS type with high bits set,
    // an empty unit, SEI swallowed, an empty array, then SPS and PPS
    add_header(1'b0, 8'hff);
    add_byte(8'd5, 1'b0);
    add_byte({2'b11, hcra_pkg::TYPE_VPS}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h02, 1'b0);
    add_unit(16'd0, 8'h00);
    add_unit(16'd1, 8'hff);
    add_byte({2'b00, TYPE_SEI}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h01, 1'b0);
    add_unit(16'd2, 8'h11);
    add_byte({2'b00, hcra_pkg::TYPE_PPS}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
    add_byte({2'b01, hcra_pkg::TYPE_SPS}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h01, 1'b0);
    add_unit(16'd3, 8'h80);
    add_byte({2'b10, hcra_pkg::TYPE_PPS}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h01, 1'b0);
    add_unit(16'd2, 8'hab);
    add_byte(8'h5a, 1'b0);
    add_byte(8'ha5, 1'b0);
    // Zero array count, then noise
    add_header(1'b1, 8'h00);
    add_byte(8'd0, 1'b0);
    add_byte(8'h33, 1'b0);
    // VPS unit cut off mid-payload by the next record
    add_header(1'b1, 8'h55);
    add_byte(8'd1, 1'b0);
    add_byte({2'b00, hcra_pkg::TYPE_VPS}, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h05, 1'b0);
    add_byte(8'hc3, 1'b0); add_byte(8'h3c, 1'b0);
    records_built = 3;
    while (record_q.size() < 310) add_random_record();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    burst = 1'b0;
    foreach (record_q[i]) begin
      if (i % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      send_record_byte(record_q[i], burst);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    drain = 0;
    while (sb.pending() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected result bytes never arrived", sb.pending()));

    $display("Covered %0d records in %0d record bytes; %0d Annex-B bytes checked.",
             records_built, record_q.size(), sb.bytes_checked);
    if (sb.err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d result bytes outstanding", sb.pending());
    $display("status: fail");
    $finish;
  end

endmodule
